[rtl/pba_pkg.sv]
// Shared types, codes and constants of the page bitmap allocator.
// No dependencies; every other file of the block but pba_ram refers to it by scoped names.
package pba_pkg;

    // Defaults of the top level parameters
    localparam int PAGES_PER_BLOCK_DEF = 16;
    localparam int TOTAL_BLOCKS_DEF    = 64;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 6;
    localparam int PAGE_W   = 4;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    // Bitmap layout: two bits per page, eight pages per memory word
    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int PAGE_BITS = 2;
    localparam int FREE_POS  = 0;
    localparam int REL_POS   = 1;

    // Configuration port
    localparam int   CFG_ADDR_W   = 3;
    localparam int   CFG_DATA_W   = 32;
    localparam int   CFG_IDX_BIT  = 2;
    localparam logic CFG_RESERVED = 1'b0;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_MARK_USED    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MARK_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND_FREE    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND_RELEASE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOCATED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE         = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE      = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BLOCK_W-1:0]  block_addr;
        logic [PAGE_W-1:0]   page_addr;
        logic [COUNT_W-1:0]  page_count;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  found_block;
        logic [PAGE_W-1:0]   found_page;
        logic [COUNT_W-1:0]  run_length;
    } res_word_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MARK_RD,
        S_MARK_WR,
        S_FIND,
        S_DIV,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_in;
        logic                mark_init;
        logic                mark_rd;
        logic                mark_wr;
        logic                find_init;
        logic                find_step;
        logic                div_init;
        logic                div_step;
        logic                clr_step;
        logic                finish;
        logic                found;
        logic [STATUS_W-1:0] code;
        logic                out_load;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic                is_mark;
        logic                cnt_zero;
        logic                start_bad;
        logic                idx_out;
        logic [STATUS_W-1:0] mark_code;
        logic                mark_last;
        logic                find_hit;
        logic                find_end;
        logic                div_done;
        logic                clr_last;
    } stat_t;

endpackage

[rtl/pba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pba_ctrl.sv]
// Sequencer of the page bitmap allocator: clearing pass, marks, scans, divide.
// Depends on pba_pkg; drives the datapath through pba_pkg::ctl_t commands.
module pba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    output logic            res_valid,
    input  logic            res_stall,
    input  pba_pkg::stat_t  stat,
    output pba_pkg::ctl_t   ctl
);

    pba_pkg::state_t state_reg;
    pba_pkg::state_t state_next;
    logic            res_valid_reg;
    logic            out_free;

    // Result register can take a new word when empty or being drained
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != pba_pkg::S_IDLE);
    assign res_valid = res_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = pba_pkg::S_DECODE;
                end
            end
            pba_pkg::S_DECODE:
            begin
                priority if (!stat.is_mark)
                begin
                    state_next = pba_pkg::S_FIND;
                end
                else if (stat.cnt_zero || stat.start_bad)
                begin
                    state_next = pba_pkg::S_DONE;
                end
                else
                begin
                    state_next = pba_pkg::S_MARK_RD;
                end
            end
            pba_pkg::S_MARK_RD:
            begin
                state_next = stat.idx_out ? pba_pkg::S_DONE : pba_pkg::S_MARK_WR;
            end
            pba_pkg::S_MARK_WR:
            begin
                if ((stat.mark_code != pba_pkg::STAT_OK) || stat.mark_last)
                begin
                    state_next = pba_pkg::S_DONE;
                end
                else
                begin
                    state_next = pba_pkg::S_MARK_RD;
                end
            end
            pba_pkg::S_FIND:
            begin
                priority if (stat.find_hit)
                begin
                    state_next = pba_pkg::S_DIV;
                end
                else if (stat.find_end)
                begin
                    state_next = pba_pkg::S_DONE;
                end
            end
            pba_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = pba_pkg::S_DONE;
                end
            end
            pba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pba_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
            end
            pba_pkg::S_IDLE:
            begin
                ctl.load_in = cmd_valid;
            end
            pba_pkg::S_DECODE:
            begin
                priority if (!stat.is_mark)
                begin
                    ctl.find_init = 1'b1;
                end
                else if (stat.cnt_zero)
                begin
                    ctl.finish = 1'b1;
                    ctl.code   = pba_pkg::STAT_OK;
                end
                else if (stat.start_bad)
                begin
                    ctl.finish = 1'b1;
                    ctl.code   = pba_pkg::STAT_RANGE;
                end
                else
                begin
                    ctl.mark_init = 1'b1;
                end
            end
            pba_pkg::S_MARK_RD:
            begin
                if (stat.idx_out)
                begin
                    ctl.finish = 1'b1;
                    ctl.code   = pba_pkg::STAT_RANGE;
                end
                else
                begin
                    ctl.mark_rd = 1'b1;
                end
            end
            pba_pkg::S_MARK_WR:
            begin
                ctl.mark_wr = 1'b1;
                if ((stat.mark_code != pba_pkg::STAT_OK) || stat.mark_last)
                begin
                    ctl.finish = 1'b1;
                    ctl.code   = stat.mark_code;
                end
            end
            pba_pkg::S_FIND:
            begin
                ctl.find_step = 1'b1;
                priority if (stat.find_hit)
                begin
                    ctl.div_init = 1'b1;
                end
                else if (stat.find_end)
                begin
                    ctl.finish = 1'b1;
                    ctl.code   = pba_pkg::STAT_NO_SPACE;
                end
            end
            pba_pkg::S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_done)
                begin
                    ctl.finish = 1'b1;
                    ctl.found  = 1'b1;
                    ctl.code   = pba_pkg::STAT_OK;
                end
            end
            pba_pkg::S_DONE:
            begin
                ctl.out_load = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // State and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pba_pkg::S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/pba_dp.sv]
// Datapath of the page bitmap allocator: bitmap memory, mark and scan logic,
// start-to-block split and result register. Depends on pba_pkg and pba_ram.
module pba_dp #(
    parameter int PAGES_PER_BLOCK = pba_pkg::PAGES_PER_BLOCK_DEF,
    parameter int TOTAL_BLOCKS    = pba_pkg::TOTAL_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pba_pkg::cmd_word_t           cmd,
    input  logic [pba_pkg::BLOCK_W-1:0]  reserved,
    input  pba_pkg::ctl_t                ctl,
    output pba_pkg::stat_t               stat,
    output pba_pkg::res_word_t           res
);

    localparam int ALL_PAGES = TOTAL_BLOCKS * PAGES_PER_BLOCK;
    localparam int IDX_RAW   = $clog2(ALL_PAGES + 1);
    localparam int IDX_W     = (IDX_RAW > pba_pkg::LANE_W + 1) ? IDX_RAW : pba_pkg::LANE_W + 1;
    localparam int WORDS     = (ALL_PAGES + pba_pkg::LANES - 1) / pba_pkg::LANES;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SC_W      = $clog2(WORDS + 1);
    localparam int PW        = AW + pba_pkg::LANE_W;
    localparam int RW        = pba_pkg::LANES * pba_pkg::PAGE_BITS;
    localparam int SEL_W     = $clog2(RW);
    localparam int TB_RAW    = $clog2(TOTAL_BLOCKS + 1);
    localparam int BK_W      = (TB_RAW > pba_pkg::BLOCK_W) ? TB_RAW : pba_pkg::BLOCK_W;
    localparam int PB_RAW    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int PG_W      = (PB_RAW > pba_pkg::PAGE_W) ? PB_RAW : pba_pkg::PAGE_W;
    localparam int RQ_W      = $clog2(PAGES_PER_BLOCK);
    localparam int DIV_W     = 1;

    // Reciprocal of the block size, exact for every run start below 2**IDX_W
    localparam int SH   = IDX_W + RQ_W;
    localparam int RC_W = IDX_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + 64'(PAGES_PER_BLOCK) - 64'd1) / 64'(PAGES_PER_BLOCK);
    localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_FULL);

    // Latched command
    logic [pba_pkg::ACTION_W-1:0] action_reg;
    logic [pba_pkg::BLOCK_W-1:0]  blk_reg;
    logic [pba_pkg::PAGE_W-1:0]   pg_reg;
    logic [pba_pkg::COUNT_W-1:0]  cnt_reg;

    // Mark walk
    logic [IDX_W-1:0]             idx_reg;
    logic [pba_pkg::COUNT_W-1:0]  left_reg;

    // Scan
    logic [SC_W-1:0]              scan_addr_reg;
    logic                         pend_reg;
    logic [AW-1:0]                pend_addr_reg;
    logic [pba_pkg::COUNT_W-1:0]  run_reg;
    logic [IDX_W-1:0]             start_reg;

    // Block and page split
    logic [IDX_W-1:0]             quo_reg;
    logic [RQ_W-1:0]              rem_reg;
    logic [DIV_W-1:0]             div_cnt_reg;

    // Clearing pass and result
    logic [AW-1:0]                clr_addr_reg;
    logic [pba_pkg::STATUS_W-1:0] status_reg;
    logic                         found_reg;
    pba_pkg::res_word_t           res_reg;

    // Memory ports
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [RW-1:0]                ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [RW-1:0]                ram_rdata;

    // Shared decode
    logic [BK_W-1:0]              res_ext;
    logic [BK_W-1:0]              blk_ext;
    logic [IDX_W-1:0]             fs_pages;
    logic [IDX_W-1:0]             start_idx;
    logic                         is_use;
    logic                         find_rel;
    logic                         scan_more;
    logic [AW-1:0]                idx_word;
    logic [pba_pkg::LANE_W-1:0]   idx_lane;

    // Mark page check
    logic [SEL_W-1:0]             sel_free;
    logic [SEL_W-1:0]             sel_rel;
    logic [pba_pkg::STATUS_W-1:0] mark_code;
    logic [RW-1:0]                mark_word;

    // Scan lanes
    logic [PW:0]                  n_lim;
    logic [pba_pkg::COUNT_W-1:0]  run_lane;
    logic [IDX_W-1:0]             start_lane;
    logic                         hit_lane;

    // Split arithmetic
    logic [IDX_W+RC_W-1:0]        div_prod;
    logic [IDX_W-1:0]             div_quo;
    logic [IDX_W-1:0]             div_back;

    assign res_ext   = BK_W'(reserved);
    assign blk_ext   = BK_W'(blk_reg);
    assign fs_pages  = (res_ext >= BK_W'(TOTAL_BLOCKS)) ? '0
                     : IDX_W'((BK_W'(TOTAL_BLOCKS) - res_ext) * PAGES_PER_BLOCK);
    assign start_idx = IDX_W'((blk_ext - res_ext) * PAGES_PER_BLOCK) + IDX_W'(pg_reg);
    assign is_use    = (action_reg == pba_pkg::ACT_MARK_USED);
    assign find_rel  = (action_reg != pba_pkg::ACT_FIND_FREE);
    assign scan_more = (scan_addr_reg < SC_W'(WORDS));
    assign idx_word  = AW'(idx_reg >> pba_pkg::LANE_W);
    assign idx_lane  = idx_reg[pba_pkg::LANE_W-1:0];

    // Status to the controller
    assign stat.is_mark   = !((action_reg == pba_pkg::ACT_FIND_FREE) ||
                              (action_reg == pba_pkg::ACT_FIND_RELEASE));
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.start_bad = (blk_ext < res_ext) || (blk_ext >= BK_W'(TOTAL_BLOCKS)) ||
                            (PG_W'(pg_reg) >= PG_W'(PAGES_PER_BLOCK));
    assign stat.idx_out   = (idx_reg >= fs_pages);
    assign stat.mark_code = mark_code;
    assign stat.mark_last = (left_reg == pba_pkg::COUNT_W'(1));
    assign stat.find_hit  = pend_reg && hit_lane;
    assign stat.find_end  = pend_reg && (pend_addr_reg == AW'(WORDS - 1));
    assign stat.div_done  = (div_cnt_reg == DIV_W'(1));
    assign stat.clr_last  = (clr_addr_reg == AW'(WORDS - 1));

    // Check one page of the word read for a mark, and clear its bit
    assign sel_free = SEL_W'(idx_lane * pba_pkg::PAGE_BITS + pba_pkg::FREE_POS);
    assign sel_rel  = SEL_W'(idx_lane * pba_pkg::PAGE_BITS + pba_pkg::REL_POS);

    always_comb
    begin
        mark_word = ram_rdata;
        priority if (is_use)
        begin
            mark_code           = ram_rdata[sel_free] ? pba_pkg::STAT_OK
                                                      : pba_pkg::STAT_ALLOCATED;
            mark_word[sel_free] = 1'b0;
        end
        else if (ram_rdata[sel_free])
        begin
            mark_code = pba_pkg::STAT_NOT_ALLOCATED;
        end
        else if (!ram_rdata[sel_rel])
        begin
            mark_code = pba_pkg::STAT_RELEASED;
        end
        else
        begin
            mark_code          = pba_pkg::STAT_OK;
            mark_word[sel_rel] = 1'b0;
        end
    end

    // Walk the eight pages of a scanned word, stopping at the first hit
    assign n_lim = (PW + 1)'(fs_pages);

    always_comb
    begin
        logic [PW-1:0] p_v;
        logic          avail_v;
        run_lane   = run_reg;
        start_lane = start_reg;
        hit_lane   = 1'b0;
        for (int j = 0; j < pba_pkg::LANES; j++)
        begin
            p_v     = {pend_addr_reg, pba_pkg::LANE_W'(j)};
            avail_v = (find_rel ? ram_rdata[j * pba_pkg::PAGE_BITS + pba_pkg::REL_POS]
                                : ram_rdata[j * pba_pkg::PAGE_BITS + pba_pkg::FREE_POS])
                      && ({1'b0, p_v} < n_lim);
            if (!hit_lane)
            begin
                if (avail_v)
                begin
                    if (run_lane == '0)
                    begin
                        start_lane = IDX_W'(p_v);
                    end
                    run_lane = run_lane + pba_pkg::COUNT_W'(1);
                    if (run_lane == cnt_reg)
                    begin
                        hit_lane = 1'b1;
                    end
                end
                else
                begin
                    run_lane = '0;
                end
            end
        end
    end

    // Split the run start: block by reciprocal multiply, page by back-multiply
    assign div_prod = (IDX_W + RC_W)'(start_reg) * (IDX_W + RC_W)'(RECIP);
    assign div_quo  = IDX_W'(div_prod >> SH);
    assign div_back = start_reg - quo_reg * IDX_W'(PAGES_PER_BLOCK);

    // Memory port selection
    assign ram_we    = ctl.clr_step || (ctl.mark_wr && (mark_code == pba_pkg::STAT_OK));
    assign ram_waddr = ctl.clr_step ? clr_addr_reg : idx_word;
    assign ram_wdata = ctl.clr_step ? '1 : mark_word;
    assign ram_re    = ctl.mark_rd || (ctl.find_step && scan_more);
    assign ram_raddr = ctl.mark_rd ? idx_word : AW'(scan_addr_reg);

    pba_ram #(
        .WIDTH (RW),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (ctl.find_init)
            begin
                pend_reg <= 1'b0;
            end
            else if (ctl.find_step)
            begin
                pend_reg <= scan_more;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            action_reg <= cmd.action;
            blk_reg    <= cmd.block_addr;
            pg_reg     <= cmd.page_addr;
            cnt_reg    <= cmd.page_count;
        end

        // Advance the mark walk on a page that passed
        if (ctl.mark_init)
        begin
            idx_reg  <= start_idx;
            left_reg <= cnt_reg;
        end
        else if (ctl.mark_wr && (mark_code == pba_pkg::STAT_OK))
        begin
            idx_reg  <= idx_reg + IDX_W'(1);
            left_reg <= left_reg - pba_pkg::COUNT_W'(1);
        end

        // Issue scan reads and fold in the word read last cycle
        if (ctl.find_init)
        begin
            scan_addr_reg <= '0;
            run_reg       <= '0;
            start_reg     <= '0;
        end
        else if (ctl.find_step)
        begin
            if (scan_more)
            begin
                scan_addr_reg <= scan_addr_reg + SC_W'(1);
                pend_addr_reg <= AW'(scan_addr_reg);
            end
            if (pend_reg)
            begin
                run_reg   <= run_lane;
                start_reg <= start_lane;
            end
        end

        // Split: block quotient first, then the page as the remainder from it
        if (ctl.div_init)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            if (div_cnt_reg == '0)
            begin
                quo_reg <= div_quo;
            end
            else
            begin
                rem_reg <= RQ_W'(div_back);
            end
            div_cnt_reg <= div_cnt_reg + DIV_W'(1);
        end

        if (ctl.finish)
        begin
            status_reg <= ctl.code;
            found_reg  <= ctl.found;
        end

        // Result word; find fields only for a found run
        if (ctl.out_load)
        begin
            res_reg.status      <= status_reg;
            res_reg.found_block <= found_reg ? pba_pkg::BLOCK_W'(quo_reg) + reserved : '0;
            res_reg.found_page  <= found_reg ? pba_pkg::PAGE_W'(rem_reg) : '0;
            res_reg.run_length  <= found_reg ? run_reg : '0;
        end
    end

    assign res = res_reg;

endmodule

[rtl/page_bitmap_allocator_top.sv]
// Top level of the page bitmap allocator: configuration register, sequencer
// and datapath. Depends on pba_pkg, pba_ctrl, pba_dp (and pba_ram below it).
//
//   channel | signals                           | word type
//   --------+-----------------------------------+---------------------
//   cmd     | cmd_valid, cmd_stall, cmd         | pba_pkg::cmd_word_t
//   res     | res_valid, res_stall, res         | pba_pkg::res_word_t
//   config  | psel penable pwrite paddr pwdata  | reserved_blocks at 0
//           | prdata pready                     |
//
// A mark reads, then checks and writes, the bitmap word of each page in turn.
// A find reads one memory word of eight pages a cycle through the bitmap until
// a run is found or the bitmap ends, and splits the start of a found run into
// block and page. After reset a clearing pass writes the bitmap to all ones,
// one word a cycle; cmd_stall stays high meanwhile, config writes work.
// One result word is held in the output register; the next command is taken
// while it waits, and that command's result holds until the register frees.
module page_bitmap_allocator_top #(
    parameter int PAGES_PER_BLOCK = pba_pkg::PAGES_PER_BLOCK_DEF,
    parameter int TOTAL_BLOCKS    = pba_pkg::TOTAL_BLOCKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  pba_pkg::cmd_word_t               cmd,
    output logic                             res_valid,
    input  logic                             res_stall,
    output pba_pkg::res_word_t               res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pba_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pba_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pba_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [pba_pkg::BLOCK_W-1:0] reserved_reg;
    logic                        reg_sel;
    pba_pkg::ctl_t               ctl;
    pba_pkg::stat_t              stat;

    // Register decode: one register, word aligned
    assign reg_sel = (paddr[pba_pkg::CFG_IDX_BIT] == pba_pkg::CFG_RESERVED);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? pba_pkg::CFG_DATA_W'(reserved_reg) : '0;

    // Write reserved_blocks in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            reserved_reg <= pwdata[pba_pkg::BLOCK_W-1:0];
        end
    end

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    pba_dp #(
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .TOTAL_BLOCKS    (TOTAL_BLOCKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .reserved (reserved_reg),
        .ctl      (ctl),
        .stat     (stat),
        .res      (res)
    );

endmodule
